@@ rtl/core/pfkc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfkc_pkg: shared types and constants
// Request and response payloads, sequencer states and slot store write
// enables for the partitioned FIFO keyed cache.
// ----------------------------------------------------------------------------
package pfkc_pkg;

	localparam int DEF_NUM_SOURCES        = 4;
	localparam int DEF_PARTITION_CAPACITY = 1024;
	localparam int DEF_KEY_BITS           = 32;

	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int SIZE_W      = 11;
	localparam int SOURCE_W    = 2;
	localparam int KEY_IN_W    = 32;
	localparam int VALUE_W     = 32;

	localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(3 * 20 * 10);
	localparam logic [CFG_W-1:0] RESERVED_RESET  = CFG_W'(300);

	localparam logic [CFG_IDX_W-1:0] REG_TRIM_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_RESERVED  = CFG_IDX_W'(1);

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [SOURCE_W-1:0] source_kind;
		logic                media_kind;
		logic [KEY_IN_W-1:0] item_key;
		logic [VALUE_W-1:0]  item_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] value_out;
		logic [SIZE_W-1:0]  partition_size;
		logic [SIZE_W-1:0]  evicted_count;
	} rsp_t;

	typedef struct packed {
		logic key;
		logic val;
		logic vld;
		logic nxt;
		logic prv;
	} slot_we_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_SCAN_DONE,
		ST_UL_RD,
		ST_UL_WR1,
		ST_UL_WR2,
		ST_UL_WR3,
		ST_FULL_CHK,
		ST_APP1,
		ST_APP2,
		ST_TRIM_TEST,
		ST_TRIM_LOOP,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/pfkc_slot_ram.sv @@
// ----------------------------------------------------------------------------
// pfkc_slot_ram: slot store
// One read port with registered data, one write port with per-field enables.
// ----------------------------------------------------------------------------
module pfkc_slot_ram
	import pfkc_pkg::*;
#(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int KW    = 32,
	parameter int LW    = 10
) (
	input  logic               clk,
	input  logic [AW-1:0]      raddr,
	input  logic [AW-1:0]      waddr,
	input  slot_we_t           we,
	input  logic [KW-1:0]      wkey,
	input  logic [VALUE_W-1:0] wval,
	input  logic               wvld,
	input  logic [LW-1:0]      wnxt,
	input  logic [LW-1:0]      wprv,
	output logic [KW-1:0]      rkey,
	output logic [VALUE_W-1:0] rval,
	output logic               rvld,
	output logic [LW-1:0]      rnxt,
	output logic [LW-1:0]      rprv
);

	logic [KW-1:0]      key_mem [DEPTH];
	logic [VALUE_W-1:0] val_mem [DEPTH];
	logic               vld_mem [DEPTH];
	logic [LW-1:0]      nxt_mem [DEPTH];
	logic [LW-1:0]      prv_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.key) key_mem[waddr] <= wkey;
		if (we.val) val_mem[waddr] <= wval;
		if (we.vld) vld_mem[waddr] <= wvld;
		if (we.nxt) nxt_mem[waddr] <= wnxt;
		if (we.prv) prv_mem[waddr] <= wprv;
	end

	always_ff @(posedge clk) begin
		rkey <= key_mem[raddr];
		rval <= val_mem[raddr];
		rvld <= vld_mem[raddr];
		rnxt <= nxt_mem[raddr];
		rprv <= prv_mem[raddr];
	end

endmodule

@@ rtl/core/partitioned_fifo_keyed_cache_top.sv @@
// ----------------------------------------------------------------------------
// partitioned_fifo_keyed_cache_top: partitioned FIFO keyed cache
// Keyed table in one slot store, one insertion-ordered linked list per
// (source, media) partition, trimmed from the oldest end after each add.
// ----------------------------------------------------------------------------
// Operation: a request with a valid source scans its whole partition, one slot read per cycle;
// an add then unlinks a replaced key or, in a full partition, the oldest entry,
// appends the new key as newest, and above the trim threshold removes oldest
// entries until the count is no more than the reserved setting.
// Throughput: one request at a time, set by the single read port of the slot store;
// a response held by the receiver holds the sequencer in its last state.
// Reset: clears control state, then sweeps the slot store marking every slot
// free with req_ready low; configuration writes are taken throughout.
module partitioned_fifo_keyed_cache_top
	import pfkc_pkg::*;
#(
	parameter int NUM_SOURCES        = DEF_NUM_SOURCES,
	parameter int PARTITION_CAPACITY = DEF_PARTITION_CAPACITY,
	parameter int KEY_BITS           = DEF_KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int NUM_PARTS = NUM_SOURCES * 2;
	localparam int NUM_SLOTS = NUM_PARTS * PARTITION_CAPACITY;
	localparam int AW        = $clog2(NUM_SLOTS);
	localparam int PW        = $clog2(NUM_PARTS);
	localparam int LW        = $clog2(PARTITION_CAPACITY);
	localparam int CW        = $clog2(PARTITION_CAPACITY + 1);
	localparam int XW        = (CW > CFG_W) ? CW : CFG_W;
	localparam int SW        = 5;

	// configuration registers
	logic [CFG_W-1:0] thr_q, rsv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			rsv_q <= RESERVED_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_TRIM_THRESHOLD) thr_q <= cfg_wdata;
			if (cfg_index == REG_TRIM_RESERVED)  rsv_q <= cfg_wdata;
		end
	end

	state_t state_q, state_d;

	// request context
	logic                op_q, bad_q;
	logic [PW-1:0]       p_q;
	logic [AW-1:0]       base_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_W-1:0]  val_in_q, val_hit_q;

	// per-partition list heads and fill counts
	logic [LW-1:0] oldest_q [NUM_PARTS];
	logic [LW-1:0] newest_q [NUM_PARTS];
	logic [CW-1:0] count_q  [NUM_PARTS];

	// scan and sequencing
	logic [AW-1:0] clr_idx_q;
	logic [LW-1:0] scan_idx_q, rd_idx_s1;
	logic          rd_pend_s1;
	logic          hit_q, free_vld_q;
	logic [LW-1:0] match_q, free_q;
	logic [LW-1:0] ul_idx_q, nx_q, pv_q, app_prev_q;
	logic          ul_evict_q, is_new_q, was_empty_q;
	state_t        ul_ret_q;
	logic [CW-1:0] evict_q;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// slot store port
	logic [AW-1:0]      mem_raddr, mem_waddr;
	slot_we_t           mem_we;
	logic [KEY_BITS-1:0] mem_wkey, mem_rkey;
	logic [VALUE_W-1:0] mem_wval, mem_rval;
	logic               mem_wvld, mem_rvld;
	logic [LW-1:0]      mem_wnxt, mem_wprv, mem_rnxt, mem_rprv;

	pfkc_slot_ram #(
		.DEPTH(NUM_SLOTS),
		.AW   (AW),
		.KW   (KEY_BITS),
		.LW   (LW)
	) u_slot_ram (
		.clk  (clk),
		.raddr(mem_raddr),
		.waddr(mem_waddr),
		.we   (mem_we),
		.wkey (mem_wkey),
		.wval (mem_wval),
		.wvld (mem_wvld),
		.wnxt (mem_wnxt),
		.wprv (mem_wprv),
		.rkey (mem_rkey),
		.rval (mem_rval),
		.rvld (mem_rvld),
		.rnxt (mem_rnxt),
		.rprv (mem_rprv)
	);

	// heads of the addressed partition
	logic [LW-1:0] cur_old, cur_new;
	logic [CW-1:0] cur_cnt;
	logic          is_old, cnt_full, over_thr, over_rsv, out_free, accept, req_bad;
	logic          scan_last;

	assign cur_old  = oldest_q[p_q];
	assign cur_new  = newest_q[p_q];
	assign cur_cnt  = count_q[p_q];
	assign is_old   = (ul_idx_q == cur_old);
	assign cnt_full = (cur_cnt == CW'(PARTITION_CAPACITY));
	assign over_thr = (XW'(cur_cnt) > XW'(thr_q));
	assign over_rsv = (XW'(cur_cnt) > XW'(rsv_q));
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign accept   = req_valid && req_ready;
	assign req_bad  = (SW'(req.source_kind) >= SW'(NUM_SOURCES));
	assign scan_last = (scan_idx_q == LW'(PARTITION_CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	// next state and slot store access
	always_comb begin
		state_d   = state_q;
		mem_raddr = base_q + AW'(scan_idx_q);
		mem_waddr = base_q + AW'(ul_idx_q);
		mem_we    = '0;
		mem_wkey  = key_q;
		mem_wval  = val_in_q;
		mem_wvld  = 1'b0;
		mem_wnxt  = '0;
		mem_wprv  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we.vld = 1'b1;
				mem_waddr  = clr_idx_q;
				if (clr_idx_q == AW'(NUM_SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = req_bad ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: state_d = ST_SCAN_DONE;
			ST_SCAN_DONE: begin
				if (op_q == OP_LOOKUP) state_d = ST_DONE;
				else if (hit_q)        state_d = ST_UL_RD;
				else                   state_d = ST_FULL_CHK;
			end
			ST_UL_RD: begin
				mem_raddr = base_q + AW'(ul_idx_q);
				state_d   = ST_UL_WR1;
			end
			ST_UL_WR1: begin
				// bridge the older neighbor over the removed slot
				if (!is_old) begin
					mem_we.nxt = 1'b1;
					mem_waddr  = base_q + AW'(mem_rprv);
					mem_wnxt   = mem_rnxt;
				end
				state_d = ST_UL_WR2;
			end
			ST_UL_WR2: begin
				if (!is_new_q) begin
					mem_we.prv = 1'b1;
					mem_waddr  = base_q + AW'(nx_q);
					mem_wprv   = pv_q;
				end
				state_d = ST_UL_WR3;
			end
			ST_UL_WR3: begin
				mem_we.vld = 1'b1;
				state_d    = ul_ret_q;
			end
			ST_FULL_CHK: state_d = cnt_full ? ST_UL_RD : ST_APP1;
			ST_APP1: begin
				mem_we    = '1;
				mem_waddr = base_q + AW'(free_q);
				mem_wvld  = 1'b1;
				mem_wprv  = (cur_cnt == '0) ? '0 : cur_new;
				state_d   = ST_APP2;
			end
			ST_APP2: begin
				if (!was_empty_q) begin
					mem_we.nxt = 1'b1;
					mem_waddr  = base_q + AW'(app_prev_q);
					mem_wnxt   = free_q;
				end
				state_d = ST_TRIM_TEST;
			end
			ST_TRIM_TEST: state_d = over_thr ? ST_TRIM_LOOP : ST_DONE;
			ST_TRIM_LOOP: state_d = over_rsv ? ST_UL_RD : ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				oldest_q[i] <= '0;
				newest_q[i] <= '0;
				count_q[i]  <= '0;
			end
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			rd_pend_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			ul_evict_q  <= 1'b0;
			is_new_q    <= 1'b0;
			was_empty_q <= 1'b0;
			ul_ret_q    <= ST_DONE;
			evict_q     <= '0;
			op_q        <= OP_ADD;
			bad_q       <= 1'b0;
			p_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_SCAN);
			// fold in the slot read issued in the previous cycle
			if (rd_pend_s1) begin
				if (mem_rvld && (mem_rkey == key_q) && !hit_q) hit_q <= 1'b1;
				if (!mem_rvld && !free_vld_q) free_vld_q <= 1'b1;
			end
			// raise the response on leaving DONE, drop it once taken
			if ((state_q == ST_DONE) && out_free) rsp_valid_q <= 1'b1;
			else if (rsp_ready)                   rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_idx_q <= clr_idx_q + AW'(1);
				ST_IDLE: begin
					if (accept) begin
						op_q       <= req.opcode;
						bad_q      <= req_bad;
						p_q        <= PW'({req.source_kind, req.media_kind});
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_vld_q <= 1'b0;
						evict_q    <= '0;
					end
				end
				ST_SCAN: scan_idx_q <= scan_idx_q + LW'(1);
				ST_SCAN_DONE: begin
					ul_evict_q <= 1'b0;
					ul_ret_q   <= ST_FULL_CHK;
				end
				ST_UL_WR1: begin
					is_new_q <= (ul_idx_q == cur_new);
					if (is_old) oldest_q[p_q] <= mem_rnxt;
				end
				ST_UL_WR2: begin
					if (is_new_q) newest_q[p_q] <= pv_q;
				end
				ST_UL_WR3: begin
					if (cur_cnt != '0) count_q[p_q] <= cur_cnt - CW'(1);
					if (ul_evict_q) evict_q <= evict_q + CW'(1);
					if (!free_vld_q || (ul_idx_q < free_q)) free_vld_q <= 1'b1;
				end
				ST_FULL_CHK: begin
					ul_evict_q <= 1'b1;
					ul_ret_q   <= ST_APP1;
				end
				ST_APP1: begin
					was_empty_q <= (cur_cnt == '0);
					if (cur_cnt == '0) oldest_q[p_q] <= free_q;
					newest_q[p_q] <= free_q;
					count_q[p_q]  <= cur_cnt + CW'(1);
				end
				ST_TRIM_LOOP: begin
					ul_evict_q <= 1'b1;
					ul_ret_q   <= ST_TRIM_LOOP;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= KEY_BITS'(req.item_key);
			val_in_q <= req.item_value;
			base_q   <= AW'(PW'({req.source_kind, req.media_kind}) * PARTITION_CAPACITY);
		end
		rd_idx_s1 <= scan_idx_q;
		if (rd_pend_s1) begin
			if (mem_rvld && (mem_rkey == key_q) && !hit_q) begin
				match_q   <= rd_idx_s1;
				val_hit_q <= mem_rval;
			end
			if (!mem_rvld && !free_vld_q) free_q <= rd_idx_s1;
		end
		unique case (state_q)
			ST_SCAN_DONE: ul_idx_q <= match_q;
			ST_FULL_CHK:  ul_idx_q <= cur_old;
			ST_TRIM_LOOP: ul_idx_q <= cur_old;
			ST_UL_WR1: begin
				nx_q <= mem_rnxt;
				pv_q <= mem_rprv;
			end
			ST_UL_WR3: begin
				// a freed slot may become the lowest free one
				if (!free_vld_q || (ul_idx_q < free_q)) free_q <= ul_idx_q;
			end
			ST_APP1: app_prev_q <= cur_new;
			ST_DONE: begin
				if (out_free) begin
					rsp_q.hit            <= !bad_q && hit_q;
					rsp_q.value_out      <= (!bad_q && hit_q && (op_q == OP_LOOKUP)) ?
						val_hit_q : '0;
					rsp_q.partition_size <= bad_q ? '0 : SIZE_W'(cur_cnt);
					rsp_q.evicted_count  <= bad_q ? '0 : SIZE_W'(evict_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: partitioned FIFO keyed cache testbench
// Drives add and lookup requests through the valid/ready request channel and
// checks every response against a queue-based model of the partitions. It
// runs a short directed table, then random phases under several trim
// settings, including a full-partition fill and a long response stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pfkc_pkg::*;

	localparam int NUM_PARTS      = DEF_NUM_SOURCES * 2;
	localparam int CAPACITY       = DEF_PARTITION_CAPACITY;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int LONG_HOLD      = 6000;
	localparam int SETTLE         = 64;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} step_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// model state: one insertion-ordered list per partition, oldest first
	logic [KEY_IN_W-1:0] part_keys[NUM_PARTS][$];
	logic [VALUE_W-1:0]  part_vals[NUM_PARTS][$];
	int unsigned         trim_thr;
	int unsigned         trim_keep;

	rsp_t pending_rsp[$];
	int   errors;
	int   idle_cycles;
	bit   calm;
	bit   long_hold;

	partitioned_fifo_keyed_cache_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Apply one request to the partition lists and return the response it gives.
	function automatic rsp_t cache_apply(req_t r);
		rsp_t o;
		int   p;
		int   found;
		int   gone;
		o = '0;
		p = r.source_kind * 2 + r.media_kind;
		found = -1;
		gone = 0;
		for (int i = 0; i < part_keys[p].size(); i++)
			if (part_keys[p][i] == r.item_key)
				found = i;
		if (r.opcode == OP_LOOKUP) begin
			if (found >= 0) begin
				o.hit = 1'b1;
				o.value_out = part_vals[p][found];
			end
		end else begin
			// drop a replaced key, make room in a full partition, append newest
			if (found >= 0) begin
				o.hit = 1'b1;
				part_keys[p].delete(found);
				part_vals[p].delete(found);
			end
			if (part_keys[p].size() >= CAPACITY) begin
				void'(part_keys[p].pop_front());
				void'(part_vals[p].pop_front());
				gone++;
			end
			part_keys[p].push_back(r.item_key);
			part_vals[p].push_back(r.item_value);
			// trim from the oldest end; nothing happens if keep is not below size
			if (part_keys[p].size() > trim_thr)
				while (part_keys[p].size() > trim_keep) begin
					void'(part_keys[p].pop_front());
					void'(part_vals[p].pop_front());
					gone++;
				end
			o.evicted_count = SIZE_W'(gone);
		end
		o.partition_size = SIZE_W'(part_keys[p].size());
		return o;
	endfunction

	// Offer one request; hold valid and payload until the block takes it.
	task automatic send_req(req_t r, bit typed, rsp_t e);
		int   gap;
		rsp_t model;
		gap = calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		model = cache_apply(r);
		pending_rsp.push_back(typed ? e : model);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TRIM_THRESHOLD)
			trim_thr = 32'(data);
		else if (idx == REG_TRIM_RESERVED)
			trim_keep = 32'(data);
	endtask

	// Withdraw the last request, wait until every response is back, then settle.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(int count, int stall_at);
		logic [KEY_IN_W-1:0] pool[12];
		req_t r;
		foreach (pool[i]) pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			if (n == stall_at)
				long_hold = 1'b1;
			r.opcode      = 1'($urandom_range(0, 1));
			r.source_kind = SOURCE_W'($urandom_range(0, 3));
			r.media_kind  = 1'($urandom_range(0, 1));
			// mostly a small key pool so replaces and lookup hits are common
			r.item_key    = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 11)];
			r.item_value  = $urandom;
			send_req(r, 1'b0, '0);
		end
	endtask

	// Flood one partition with new keys so it reaches capacity.
	task automatic fill_phase(int count);
		req_t r;
		for (int n = 0; n < count; n++) begin
			r.opcode      = OP_ADD;
			r.source_kind = 2'd0;
			r.media_kind  = 1'b1;
			r.item_key    = $urandom;
			r.item_value  = $urandom;
			send_req(r, 1'b0, '0);
		end
	endtask

	// Response side: random stalls, and one long hold-off when asked.
	initial begin
		int stall;
		rsp_ready = 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (long_hold) begin
				stall = LONG_HOLD;
				long_hold = 1'b0;
			end
			@(negedge clk);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Check each accepted response against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.hit !== want.hit) begin
					errors++;
					$display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp.hit);
				end
				if (rsp.value_out !== want.value_out) begin
					errors++;
					$display("%0t: value_out expected %h actual %h", $time,
						want.value_out, rsp.value_out);
				end
				if (rsp.partition_size !== want.partition_size) begin
					errors++;
					$display("%0t: partition_size expected %0d actual %0d", $time,
						want.partition_size, rsp.partition_size);
				end
				if (rsp.evicted_count !== want.evicted_count) begin
					errors++;
					$display("%0t: evicted_count expected %0d actual %0d", $time,
						want.evicted_count, rsp.evicted_count);
				end
			end
		end
	end

	// Stop a hung run: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Directed rows: typed responses where they follow directly from reset
	// state; the rest come from the model.
	step_row_t directed[18] = '{
		'{'{OP_LOOKUP, 2'd0, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 11'd0, 11'd0}},
		'{'{OP_ADD,    2'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
			'{1'b0, 32'h0000_0000, 11'd1, 11'd0}},
		'{'{OP_LOOKUP, 2'd0, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 11'd1, 11'd0}},
		'{'{OP_ADD,    2'd0, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'h0000_0000, 11'd1, 11'd0}},
		'{'{OP_LOOKUP, 2'd0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
			'{1'b1, 32'h0000_0000, 11'd1, 11'd0}},
		'{'{OP_ADD,    2'd3, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678}, 1'b1,
			'{1'b0, 32'h0000_0000, 11'd1, 11'd0}},
		'{'{OP_LOOKUP, 2'd3, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b0, 32'h0000_0000, 11'd0, 11'd0}},
		'{'{OP_LOOKUP, 2'd3, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
			'{1'b1, 32'h1234_5678, 11'd1, 11'd0}},
		'{'{OP_ADD,    2'd1, 1'b0, 32'h8000_0000, 32'hA5A5_A5A5}, 1'b0, '0},
		'{'{OP_ADD,    2'd1, 1'b1, 32'h0000_0001, 32'h5A5A_5A5A}, 1'b0, '0},
		'{'{OP_ADD,    2'd2, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0},
		'{'{OP_ADD,    2'd2, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF}, 1'b0, '0},
		'{'{OP_ADD,    2'd1, 1'b0, 32'h0000_0001, 32'h0000_0001}, 1'b0, '0},
		'{'{OP_LOOKUP, 2'd1, 1'b0, 32'h8000_0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_LOOKUP, 2'd2, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_ADD,    2'd0, 1'b0, 32'h0000_0002, 32'h0000_0002}, 1'b0, '0},
		'{'{OP_LOOKUP, 2'd0, 1'b0, 32'h0000_0002, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_LOOKUP, 2'd2, 1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0}
	};

	initial begin
		req_t big;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		idle_cycles = 0;
		calm = 1'b0;
		long_hold = 1'b0;
		trim_thr = 32'(THRESHOLD_RESET);
		trim_keep = 32'(RESERVED_RESET);
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults: walk the directed table
		foreach (directed[i])
			send_req(directed[i].r, directed[i].typed, directed[i].e);
		drain();

		// tight trimming; the spare index must be ignored
		write_reg(REG_TRIM_THRESHOLD, CFG_W'(4));
		write_reg(REG_TRIM_RESERVED, CFG_W'(2));
		write_reg(REG_SPARE, CFG_W'($urandom));
		random_phase(60, 20);
		drain();

		// no trim below capacity: a partition fills up, then sheds its oldest
		// entry on every further add
		write_reg(REG_TRIM_THRESHOLD, CFG_W'(1));
		write_reg(REG_TRIM_RESERVED, CFG_W'(1023));
		fill_phase(CAPACITY + 8);
		random_phase(20, -1);
		drain();

		// full partition with trim to zero: one add evicts everything
		write_reg(REG_TRIM_THRESHOLD, CFG_W'(1023));
		write_reg(REG_TRIM_RESERVED, CFG_W'(0));
		big.opcode = OP_ADD;
		big.source_kind = 2'd0;
		big.media_kind = 1'b1;
		big.item_key = $urandom;
		big.item_value = $urandom;
		send_req(big, 1'b0, '0);
		random_phase(20, -1);
		drain();

		write_reg(REG_TRIM_RESERVED, CFG_W'(1023));
		random_phase(20, -1);
		drain();

		// reserved equal to threshold, with a stretch of back-to-back traffic
		write_reg(REG_TRIM_THRESHOLD, CFG_W'(3));
		write_reg(REG_TRIM_RESERVED, CFG_W'(3));
		calm = 1'b1;
		random_phase(20, -1);
		calm = 1'b0;
		random_phase(20, -1);
		@(negedge clk);
		req_valid <= 1'b0;
		drain();

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
